// ===== sv/stq_pkg.sv =====
// Shared types and constants for the sorted timer queue.
`timescale 1ns / 1ps
package stq_pkg;

  localparam int ID_W      = 5;
  localparam int FUNC_W    = 3;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 2;
  localparam int IN_TIME_W = 32;
  localparam int DELAY_W   = 32;

  // command codes
  localparam logic [FUNC_W-1:0] FN_REGISTER = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SCHEDULE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_QUERY    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_TICK     = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PROGRAM = 2'd2;

  // reply status
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP     = 2'd2;

  // datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_REG_ADD,
    OP_RD_IDX,
    OP_NEXT,
    OP_SET_AUX1,
    OP_SHL_RD,
    OP_SHL_WR,
    OP_SHL_DONE,
    OP_CLEAR_K,
    OP_SCHED_SET,
    OP_SET_POS,
    OP_SHR_RD,
    OP_SHR_WR,
    OP_INS_WR,
    OP_TICK_SET,
    OP_RD_HEAD,
    OP_RD_SECOND,
    OP_EMIT_EXP,
    OP_EMIT_REQ,
    OP_CLR_PROG,
    OP_EMIT_REPLY
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND_RD,
    S_FIND_CHK,
    S_SHL_CHK,
    S_SHL_WR,
    S_AFTER_SHL,
    S_INS_CHK,
    S_INS_TST,
    S_SHR_CHK,
    S_SHR_WR,
    S_TICK_CHK,
    S_TICK_TST,
    S_HEAD,
    S_HEAD_TST,
    S_SEC_RD,
    S_SEC_CLR,
    S_REPLY
  } ctrl_state_t;

  typedef struct packed {
    logic              out_free;
    logic              cnt_zero;
    logic              cnt_gt1;
    logic              full;
    logic              idx_at_end;
    logic              shl_more;
    logic              shr_more;
    logic              rd_match;
    logic              ins_here;
    logic              expired;
    logic              head_prog;
    logic              id_ok;
    logic              known;
    logic [FUNC_W-1:0] func;
  } dp_stat_t;

endpackage

// ===== sv/stq_ifs.sv =====
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
interface stq_in_if import stq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [ID_W-1:0]      timer_id;
  logic [IN_TIME_W-1:0] deadline;
  logic [IN_TIME_W-1:0] now;
  modport source(output valid, func, timer_id, deadline, now, input ready);
  modport sink(input valid, func, timer_id, deadline, now, output ready);
endinterface

interface stq_out_if import stq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ID_W-1:0]    out_id;
  logic [STAT_W-1:0]  status;
  logic               was_armed;
  logic               is_pending;
  logic               is_registered;
  logic [DELAY_W-1:0] delay;
  logic               last;
  modport source(output valid, kind, out_id, status, was_armed, is_pending,
                 is_registered, delay, last, input ready);
  modport sink(input valid, kind, out_id, status, was_armed, is_pending,
               is_registered, delay, last, output ready);
endinterface

// ===== sv/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: controller plus datapath.
`timescale 1ns / 1ps
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        func, timer_id, deadline, now
//  out_ch   out  valid/ready        kind, out_id, status, was_armed,
//                                   is_pending, is_registered, delay, last
//
// One command transaction is taken at a time; in_ch.ready is high only while
// the controller is idle. Register, query and unknown commands go straight to
// the reply; delete walks the list to the timer's slot and shifts the rest left;
// schedule adds a scan for the insert position and a shift right; tick emits an
// expiry per expired entry, then compacts the survivors. Schedule and tick then
// check the head; a program request with a successor behind it also clears the
// successor's program flag. The list memory does one read and one write per cycle.
// Reset is synchronous and needs no clearing pass; the flag vectors clear at once.
// A stalled out_ch holds the controller in place; nothing is dropped.
module sorted_timer_queue import stq_pkg::*; #(
  parameter int NUM_TIMERS = 32,
  parameter int TIME_BITS  = 32
) (
  input logic      clk,
  input logic      rst_n,
  stq_in_if.sink   in_ch,
  stq_out_if.source out_ch
);

  dp_op_t   op;
  dp_stat_t stat;

  // sequencer: one micro-op per cycle into the datapath
  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .op       (op)
  );

  // list memory, flags and result register
  stq_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .stat              (stat),
    .in_func           (in_ch.func),
    .in_timer_id       (in_ch.timer_id),
    .in_deadline       (in_ch.deadline),
    .in_now            (in_ch.now),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_kind          (out_ch.kind),
    .out_id            (out_ch.out_id),
    .out_status        (out_ch.status),
    .out_was_armed     (out_ch.was_armed),
    .out_is_pending    (out_ch.is_pending),
    .out_is_registered (out_ch.is_registered),
    .out_delay         (out_ch.delay),
    .out_last          (out_ch.last)
  );

endmodule

// ===== sv/stq_dp.sv =====
// Datapath: ordered list memory, timer flags, walk counters and result register.
`timescale 1ns / 1ps
module stq_dp import stq_pkg::*; #(
  parameter int NUM_TIMERS = 32,
  parameter int TIME_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_op_t               op,
  output dp_stat_t             stat,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [ID_W-1:0]      in_timer_id,
  input  logic [IN_TIME_W-1:0] in_deadline,
  input  logic [IN_TIME_W-1:0] in_now,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [KIND_W-1:0]    out_kind,
  output logic [ID_W-1:0]      out_id,
  output logic [STAT_W-1:0]    out_status,
  output logic                 out_was_armed,
  output logic                 out_is_pending,
  output logic                 out_is_registered,
  output logic [DELAY_W-1:0]   out_delay,
  output logic                 out_last
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef logic [TIME_BITS-1:0] tm_t;
  localparam tm_t TM_ONES = '1;

  // list memory: id and deadline side by side, one entry per list slot
  logic [ID_W-1:0] mem_id [NUM_TIMERS];
  tm_t             mem_dl [NUM_TIMERS];
  logic [ID_W-1:0] rd_id_r;
  tm_t             rd_dl_r;

  logic [FUNC_W-1:0] func_r;
  logic [ID_W-1:0]   id_r;
  tm_t               dl_r;
  tm_t               now_r;
  logic [CW-1:0]     cnt_r, idx_r, aux_r;

  logic [NUM_TIMERS-1:0] reg_f_r, pend_f_r, prog_f_r, arm_f_r;

  logic [STAT_W-1:0] status_r;
  logic              armed_r, pend_r, regq_r;

  logic               out_valid_r;
  logic [KIND_W-1:0]  kind_r;
  logic [ID_W-1:0]    oid_r;
  logic [STAT_W-1:0]  ostat_r;
  logic               oarm_r, opend_r, oreg_r, olast_r;
  logic [DELAY_W-1:0] odelay_r;

  logic [IW-1:0] k, rk, in_k, rd_addr, wr_addr;
  logic          id_ok, known, in_ok, in_known;
  logic [CW:0]   sum;
  logic [CW-1:0] idx_m1;
  logic          rd_en, wr_en;
  logic [ID_W-1:0] wr_id;
  tm_t           wr_dl;
  tm_t           diff;
  logic          out_free;
  logic [STAT_W-1:0] ld_status;
  logic          ld_armed, ld_pend, ld_regq;

  assign k        = IW'(id_r);
  assign rk       = IW'(rd_id_r);
  assign in_k     = IW'(in_timer_id);
  assign id_ok    = 9'(id_r) < 9'(NUM_TIMERS);
  assign known    = id_ok && reg_f_r[k];
  assign in_ok    = 9'(in_timer_id) < 9'(NUM_TIMERS);
  assign in_known = in_ok && reg_f_r[in_k];
  assign sum      = {1'b0, idx_r} + {1'b0, aux_r};
  assign idx_m1   = idx_r - CW'(1);
  assign diff     = (rd_dl_r > now_r) ? (rd_dl_r - now_r) : '0;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx_r[IW-1:0];
    wr_id   = rd_id_r;
    wr_dl   = rd_dl_r;
    case (op)
      OP_RD_IDX: begin
        rd_en   = 1'b1;
        rd_addr = idx_r[IW-1:0];
      end
      OP_SHL_RD: begin
        rd_en   = 1'b1;
        rd_addr = sum[IW-1:0];
      end
      OP_SHR_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_m1[IW-1:0];
      end
      OP_RD_HEAD: begin
        rd_en   = 1'b1;
      end
      OP_RD_SECOND: begin
        rd_en   = 1'b1;
        rd_addr = IW'(1);
      end
      OP_REG_ADD: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[IW-1:0];
        wr_id   = id_r;
        wr_dl   = TM_ONES;
      end
      OP_SHL_WR, OP_SHR_WR: begin
        wr_en   = 1'b1;
      end
      OP_INS_WR: begin
        wr_en   = 1'b1;
        wr_id   = id_r;
        wr_dl   = dl_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr] <= wr_id;
      mem_dl[wr_addr] <= wr_dl;
    end
    if (rd_en) begin
      rd_id_r <= mem_id[rd_addr];
      rd_dl_r <= mem_dl[rd_addr];
    end
  end

  // reply fields decided from the incoming command
  always_comb begin
    ld_status = ST_OK;
    ld_armed  = 1'b0;
    ld_pend   = 1'b0;
    ld_regq   = 1'b0;
    case (in_func)
      FN_REGISTER: begin
        if (!in_ok) begin
          ld_status = ST_UNKNOWN;
        end else if (in_known) begin
          ld_status = ST_DUP;
        end
      end
      FN_DELETE, FN_SCHEDULE: begin
        if (!in_known) begin
          ld_status = ST_UNKNOWN;
        end else begin
          ld_armed = arm_f_r[in_k];
        end
      end
      FN_QUERY: begin
        if (!in_known) begin
          ld_status = ST_UNKNOWN;
        end else begin
          ld_pend = pend_f_r[in_k];
          ld_regq = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // captured command and its reply fields
  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      func_r   <= in_func;
      id_r     <= in_timer_id;
      dl_r     <= TIME_BITS'(in_deadline);
      now_r    <= TIME_BITS'(in_now);
      status_r <= ld_status;
      armed_r  <= ld_armed;
      pend_r   <= ld_pend;
      regq_r   <= ld_regq;
    end
  end

  // list count, walk index and shift amount / insert position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
      aux_r <= '0;
    end else begin
      case (op)
        OP_LOAD: begin
          idx_r <= '0;
          aux_r <= '0;
        end
        OP_REG_ADD, OP_INS_WR: cnt_r <= cnt_r + CW'(1);
        OP_NEXT, OP_SHL_WR, OP_EMIT_EXP: idx_r <= idx_r + CW'(1);
        OP_SET_AUX1: aux_r <= CW'(1);
        OP_SHL_DONE: cnt_r <= cnt_r - aux_r;
        OP_SCHED_SET: idx_r <= '0;
        OP_SET_POS: begin
          aux_r <= idx_r;
          idx_r <= cnt_r;
        end
        OP_SHR_WR: idx_r <= idx_m1;
        OP_TICK_SET: begin
          aux_r <= idx_r;
          idx_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // per-timer flags; a timer that is not registered reads as reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_f_r  <= '0;
      pend_f_r <= '0;
      prog_f_r <= '0;
      arm_f_r  <= '0;
    end else begin
      case (op)
        OP_REG_ADD: begin
          reg_f_r[k]  <= 1'b1;
          pend_f_r[k] <= 1'b0;
          prog_f_r[k] <= 1'b0;
          arm_f_r[k]  <= 1'b0;
        end
        OP_CLEAR_K: begin
          reg_f_r[k]  <= 1'b0;
          pend_f_r[k] <= 1'b0;
          prog_f_r[k] <= 1'b0;
          arm_f_r[k]  <= 1'b0;
        end
        OP_SCHED_SET: begin
          pend_f_r[k] <= 1'b1;
          prog_f_r[k] <= 1'b0;
          arm_f_r[k]  <= (dl_r != TM_ONES);
        end
        OP_EMIT_EXP: begin
          reg_f_r[rk]  <= 1'b0;
          pend_f_r[rk] <= 1'b0;
          prog_f_r[rk] <= 1'b0;
          arm_f_r[rk]  <= 1'b0;
        end
        OP_EMIT_REQ: prog_f_r[rk] <= 1'b1;
        OP_CLR_PROG: prog_f_r[rk] <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_EMIT_EXP || op == OP_EMIT_REQ || op == OP_EMIT_REPLY) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_EMIT_EXP, OP_EMIT_REQ: begin
        kind_r   <= (op == OP_EMIT_EXP) ? KIND_EXPIRE : KIND_PROGRAM;
        oid_r    <= rd_id_r;
        ostat_r  <= ST_OK;
        oarm_r   <= 1'b0;
        opend_r  <= 1'b0;
        oreg_r   <= 1'b0;
        odelay_r <= (op == OP_EMIT_REQ) ? DELAY_W'(diff) : '0;
        olast_r  <= 1'b0;
      end
      OP_EMIT_REPLY: begin
        kind_r   <= KIND_REPLY;
        oid_r    <= '0;
        ostat_r  <= status_r;
        oarm_r   <= armed_r;
        opend_r  <= pend_r;
        oreg_r   <= regq_r;
        odelay_r <= '0;
        olast_r  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_id            = oid_r;
  assign out_status        = ostat_r;
  assign out_was_armed     = oarm_r;
  assign out_is_pending    = opend_r;
  assign out_is_registered = oreg_r;
  assign out_delay         = odelay_r;
  assign out_last          = olast_r;

  always_comb begin
    stat.out_free   = out_free;
    stat.cnt_zero   = (cnt_r == '0);
    stat.cnt_gt1    = (cnt_r > CW'(1));
    stat.full       = (cnt_r == CW'(NUM_TIMERS));
    stat.idx_at_end = (idx_r == cnt_r);
    stat.shl_more   = (aux_r != '0) && (sum < {1'b0, cnt_r});
    stat.shr_more   = (idx_r > aux_r);
    stat.rd_match   = (rd_id_r == id_r);
    stat.ins_here   = (dl_r <= rd_dl_r);
    stat.expired    = (rd_dl_r <= now_r);
    stat.head_prog  = prog_f_r[rk];
    stat.id_ok      = id_ok;
    stat.known      = known;
    stat.func       = func_r;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NUM_TIMERS)) else $error("list count beyond capacity");
  a_pend_reg: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_f_r & ~reg_f_r) == '0) else $error("pending timer not registered");
  a_prog_reg: assert property (@(posedge clk) disable iff (!rst_n)
    (prog_f_r & ~reg_f_r) == '0) else $error("programmed timer not registered");
  a_arm_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (arm_f_r & ~pend_f_r) == '0) else $error("armed timer not pending");

endmodule

// ===== sv/stq_ctrl.sv =====
// Controller: sequences list walks, shifts and result emission per command.
`timescale 1ns / 1ps
module stq_ctrl import stq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (stat.func)
          FN_DELETE, FN_SCHEDULE: state_nxt = stat.known ? S_FIND_RD : S_REPLY;
          FN_TICK: state_nxt = S_TICK_CHK;
          default: state_nxt = S_REPLY;
        endcase
      end
      S_FIND_RD:  state_nxt = S_FIND_CHK;
      S_FIND_CHK: state_nxt = stat.rd_match ? S_SHL_CHK : S_FIND_RD;
      S_SHL_CHK:  state_nxt = stat.shl_more ? S_SHL_WR : S_AFTER_SHL;
      S_SHL_WR:   state_nxt = S_SHL_CHK;
      S_AFTER_SHL: begin
        case (stat.func)
          FN_SCHEDULE: state_nxt = S_INS_CHK;
          FN_TICK:     state_nxt = S_HEAD;
          default:     state_nxt = S_REPLY;
        endcase
      end
      S_INS_CHK:  state_nxt = stat.idx_at_end ? S_SHR_CHK : S_INS_TST;
      S_INS_TST:  state_nxt = stat.ins_here ? S_SHR_CHK : S_INS_CHK;
      S_SHR_CHK:  state_nxt = stat.shr_more ? S_SHR_WR : S_HEAD;
      S_SHR_WR:   state_nxt = S_SHR_CHK;
      S_TICK_CHK: state_nxt = stat.idx_at_end ? S_SHL_CHK : S_TICK_TST;
      S_TICK_TST: begin
        if (!stat.expired) begin
          state_nxt = S_SHL_CHK;
        end else if (stat.out_free) begin
          state_nxt = S_TICK_CHK;
        end
      end
      S_HEAD:     state_nxt = stat.cnt_zero ? S_REPLY : S_HEAD_TST;
      S_HEAD_TST: begin
        if (stat.head_prog) begin
          state_nxt = S_REPLY;
        end else if (stat.out_free) begin
          state_nxt = stat.cnt_gt1 ? S_SEC_RD : S_REPLY;
        end
      end
      S_SEC_RD:   state_nxt = S_SEC_CLR;
      S_SEC_CLR:  state_nxt = S_REPLY;
      S_REPLY:    if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LOAD;
      end
      S_DISPATCH: begin
        if (stat.func == FN_REGISTER && stat.id_ok && !stat.known && !stat.full) begin
          op = OP_REG_ADD;
        end
      end
      S_FIND_RD:  op = OP_RD_IDX;
      S_FIND_CHK: op = stat.rd_match ? OP_SET_AUX1 : OP_NEXT;
      S_SHL_CHK:  op = stat.shl_more ? OP_SHL_RD : OP_SHL_DONE;
      S_SHL_WR:   op = OP_SHL_WR;
      S_AFTER_SHL: begin
        if (stat.func == FN_DELETE) begin
          op = OP_CLEAR_K;
        end else if (stat.func == FN_SCHEDULE) begin
          op = OP_SCHED_SET;
        end
      end
      S_INS_CHK:  op = stat.idx_at_end ? OP_SET_POS : OP_RD_IDX;
      S_INS_TST:  op = stat.ins_here ? OP_SET_POS : OP_NEXT;
      S_SHR_CHK:  op = stat.shr_more ? OP_SHR_RD : OP_INS_WR;
      S_SHR_WR:   op = OP_SHR_WR;
      S_TICK_CHK: op = stat.idx_at_end ? OP_TICK_SET : OP_RD_IDX;
      S_TICK_TST: begin
        if (!stat.expired) begin
          op = OP_TICK_SET;
        end else if (stat.out_free) begin
          op = OP_EMIT_EXP;
        end
      end
      S_HEAD:     if (!stat.cnt_zero) op = OP_RD_HEAD;
      S_HEAD_TST: if (!stat.head_prog && stat.out_free) op = OP_EMIT_REQ;
      S_SEC_RD:   op = OP_RD_SECOND;
      S_SEC_CLR:  op = OP_CLR_PROG;
      S_REPLY:    if (stat.out_free) op = OP_EMIT_REPLY;
      default:    op = OP_NONE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT_EXP || op == OP_EMIT_REQ || op == OP_EMIT_REPLY) |-> stat.out_free)
    else $error("result issued into a full output register");
  a_reply_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT_REPLY) |=> state_r == S_IDLE)
    else $error("command not finished after its reply");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_LOAD) |-> state_r == S_IDLE)
    else $error("command loaded while busy");

endmodule

// ===== verif/stq_tb_ifs.sv =====
// Testbench types: the expected result transaction record.
`timescale 1ns / 1ps
package stq_tb_types;
  import stq_pkg::*;

  // one expected result transaction
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    out_id;
    logic [STAT_W-1:0]  status;
    logic               was_armed;
    logic               is_pending;
    logic               is_registered;
    logic [DELAY_W-1:0] delay;
    logic               last;
  } stq_result_t;
endpackage

// ===== verif/stq_checker.sv =====
// Watches both channels, predicts the timer queue's results and compares.
`timescale 1ns / 1ps
module stq_checker import stq_pkg::*; import stq_tb_types::*; (
  input  logic     clk,
  input  logic     rst_n,
  stq_in_if.sink   in_mon,
  stq_out_if.sink  out_mon,
  output int       fail_count,
  output int       outstanding
);
  localparam int NT = 32;
  localparam logic [31:0] NO_DEADLINE = 32'hFFFF_FFFF;

  logic [ID_W-1:0] order_q [$];
  logic [31:0]     deadline_of [NT];
  bit              pending_of [NT];
  bit              armed_hw [NT];
  bit              present [NT];
  stq_result_t     expected_q [$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic void push_res(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
                                   input logic [STAT_W-1:0] st, input bit a, input bit p,
                                   input bit r, input logic [31:0] d, input bit l);
    stq_result_t e;
    e = '{k, id, st, a, p, r, d, l};
    expected_q.push_back(e);
  endfunction

  function automatic void drop_timer(input logic [ID_W-1:0] id);
    int i;
    for (i = order_q.size() - 1; i >= 0; i--)
      if (order_q[i] == id) order_q.delete(i);
    deadline_of[id] = NO_DEADLINE;
    pending_of[id] = 0;
    armed_hw[id] = 0;
    present[id] = 0;
  endfunction

  // head not yet programmed: one-shot request, successor loses its programming
  function automatic void arm_head(input logic [31:0] now);
    logic [ID_W-1:0] h;
    if (order_q.size() == 0) return;
    h = order_q[0];
    if (armed_hw[h]) return;
    push_res(KIND_PROGRAM, h, ST_OK, 0, 0, 0,
             deadline_of[h] > now ? deadline_of[h] - now : 32'd0, 0);
    armed_hw[h] = 1;
    if (order_q.size() > 1) armed_hw[order_q[1]] = 0;
  endfunction

  function automatic void predict_command(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                                          input logic [31:0] dl, input logic [31:0] now);
    logic [STAT_W-1:0] st;
    bit a, p, r;
    int pos;
    st = ST_OK; a = 0; p = 0; r = 0;
    case (fn)
      FN_REGISTER: begin
        if (present[id]) st = ST_DUP;
        else if (order_q.size() < NT) begin
          drop_timer(id);
          present[id] = 1;
          order_q.push_back(id);
        end
      end
      FN_DELETE: begin
        if (!present[id]) st = ST_UNKNOWN;
        else begin
          a = deadline_of[id] != NO_DEADLINE;
          drop_timer(id);
        end
      end
      FN_SCHEDULE: begin
        if (!present[id]) st = ST_UNKNOWN;
        else begin
          a = deadline_of[id] != NO_DEADLINE;
          for (pos = order_q.size() - 1; pos >= 0; pos--)
            if (order_q[pos] == id) order_q.delete(pos);
          deadline_of[id] = dl;
          pending_of[id] = 1;
          armed_hw[id] = 0;
          for (pos = 0; pos < order_q.size(); pos++)
            if (dl <= deadline_of[order_q[pos]]) break;
          order_q.insert(pos, id);
          arm_head(now);
        end
      end
      FN_QUERY: begin
        if (!present[id]) st = ST_UNKNOWN;
        else begin
          p = pending_of[id];
          r = 1;
        end
      end
      FN_TICK: begin
        while (order_q.size() > 0 && deadline_of[order_q[0]] <= now) begin
          push_res(KIND_EXPIRE, order_q[0], ST_OK, 0, 0, 0, 0, 0);
          drop_timer(order_q[0]);
        end
        arm_head(now);
      end
      default: ;
    endcase
    push_res(KIND_REPLY, '0, st, a, p, r, 0, 1);
  endfunction

  always @(posedge clk) begin
    stq_result_t e;
    if (!rst_n) begin
      order_q.delete();
      expected_q.delete();
      fail_count = 0;
      for (int i = 0; i < NT; i++) begin
        deadline_of[i] = NO_DEADLINE;
        pending_of[i] = 0;
        armed_hw[i] = 0;
        present[i] = 0;
      end
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) report("result with nothing expected");
        else begin
          e = expected_q.pop_front();
          if (out_mon.kind !== e.kind) report($sformatf("kind %0d exp %0d", out_mon.kind, e.kind));
          if (out_mon.out_id !== e.out_id)
            report($sformatf("out_id %0d exp %0d", out_mon.out_id, e.out_id));
          if (out_mon.status !== e.status)
            report($sformatf("status %0d exp %0d", out_mon.status, e.status));
          if (out_mon.was_armed !== e.was_armed) report("was_armed differs");
          if (out_mon.is_pending !== e.is_pending) report("is_pending differs");
          if (out_mon.is_registered !== e.is_registered) report("is_registered differs");
          if (out_mon.delay !== e.delay)
            report($sformatf("delay %0d exp %0d", out_mon.delay, e.delay));
          if (out_mon.last !== e.last) report("last differs");
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_command(in_mon.func, in_mon.timer_id, in_mon.deadline, in_mon.now);
    end
    outstanding <= expected_q.size();
  end
endmodule

// ===== verif/sorted_timer_queue_tb.sv =====
// Top of the sorted timer queue testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module sorted_timer_queue_tb;
  import stq_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  bit   hold_off;   // long receiver stall requested by the stimulus
  bit   stall_on;   // receiver stalls at random when set

  stq_in_if  in_ch();
  stq_out_if out_ch();

  sorted_timer_queue uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  stq_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                   .fail_count(fail_count), .outstanding(outstanding));

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Software clock that moves forward with ticks; deadlines are picked near it
  // so that ticks really expire timers.
  logic [31:0] sw_now;
  int          burst_left;

  // Receiver: random stall pattern, plus one long hold-off when asked.
  initial begin
    int hold_cycles;
    bit hold_done;
    hold_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 400) begin
          @(negedge clk);
          hold_cycles++;
        end
        hold_done = 1;
      end else if (stall_on)
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      else
        out_ch.ready <= 1'b1;
    end
  end

  // Offer one command transaction, hold it until accepted, then gap or keep
  // valid high for the next transaction of the burst.
  task automatic send_cmd(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                          input logic [31:0] dl, input logic [31:0] now);
    in_ch.valid    <= 1'b1;
    in_ch.func     <= fn;
    in_ch.timer_id <= id;
    in_ch.deadline <= dl;
    in_ch.now      <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    else begin
      in_ch.valid    <= 1'b0;
      in_ch.func     <= FUNC_W'($urandom_range(0, 7));
      in_ch.deadline <= $urandom;
      burst_left = $urandom_range(0, 6);
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has come.
  task automatic drain_all();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Random command, weighted toward well-formed schedule/tick traffic.
  task automatic random_cmd();
    int pick;
    logic [31:0] dl;
    pick = $urandom_range(0, 99);
    dl = sw_now + $urandom_range(0, 300);
    if ($urandom_range(0, 15) == 0) dl = $urandom;
    if ($urandom_range(0, 30) == 0) dl = 32'hFFFF_FFFF;
    if (pick < 20)      send_cmd(FN_REGISTER, ID_W'($urandom_range(0, 31)), $urandom, sw_now);
    else if (pick < 30) send_cmd(FN_DELETE, ID_W'($urandom_range(0, 31)), $urandom, sw_now);
    else if (pick < 60) send_cmd(FN_SCHEDULE, ID_W'($urandom_range(0, 31)), dl, sw_now);
    else if (pick < 70) send_cmd(FN_QUERY, ID_W'($urandom_range(0, 31)), $urandom, sw_now);
    else if (pick < 97) begin
      sw_now = sw_now + $urandom_range(0, 120);
      send_cmd(FN_TICK, ID_W'($urandom_range(0, 31)), $urandom, sw_now);
    end else
      send_cmd(FUNC_W'($urandom_range(5, 7)), ID_W'($urandom_range(0, 31)), $urandom,
               $urandom);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FN_REGISTER;
    in_ch.timer_id = '0;
    in_ch.deadline = '0;
    in_ch.now      = '0;
    hold_off       = 0;
    stall_on       = 0;
    burst_left     = 0;
    sw_now         = 32'd1000;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: unknown ids, duplicates, every command, extreme times,
    // unscheduled timers expired by an all-ones tick, unused codes.
    send_cmd(FN_DELETE, 5'd31, 32'd0, 32'd0);
    send_cmd(FN_QUERY, 5'd0, 32'd0, 32'd0);
    send_cmd(FN_SCHEDULE, 5'd3, 32'd5, 32'd0);
    send_cmd(FN_TICK, 5'd0, 32'd0, 32'd0);
    send_cmd(FN_REGISTER, 5'd0, 32'd0, 32'd0);
    send_cmd(FN_REGISTER, 5'd31, 32'd0, 32'd0);
    send_cmd(FN_REGISTER, 5'd31, 32'd0, 32'd0);
    send_cmd(FN_REGISTER, 5'd7, 32'd0, 32'd0);
    send_cmd(FN_TICK, 5'd0, 32'd0, 32'hFFFF_FFFE);
    send_cmd(FN_SCHEDULE, 5'd7, 32'd0, 32'hFFFF_FFFF);
    send_cmd(FN_SCHEDULE, 5'd31, 32'hFFFF_FFFF, 32'd0);
    send_cmd(FN_SCHEDULE, 5'd0, 32'd0, 32'd10);
    send_cmd(FN_QUERY, 5'd0, 32'd0, 32'd0);
    send_cmd(FN_QUERY, 5'd7, 32'd0, 32'd0);
    send_cmd(FN_SCHEDULE, 5'd0, 32'd100, 32'd0);
    send_cmd(FN_DELETE, 5'd7, 32'd0, 32'd0);
    send_cmd(3'd5, 5'd21, 32'hAAAA_5555, 32'h5555_AAAA);
    send_cmd(3'd7, 5'd10, 32'd0, 32'd0);
    send_cmd(FN_TICK, 5'd0, 32'd0, 32'd50);
    send_cmd(FN_TICK, 5'd0, 32'd0, 32'hFFFF_FFFF);
    send_cmd(FN_QUERY, 5'd31, 32'd0, 32'd0);
    drain_all();

    // Fill the list completely, then schedule all: deepest inserts and sweeps.
    for (int i = 0; i < 32; i++) send_cmd(FN_REGISTER, i[4:0], 32'd0, sw_now);
    send_cmd(FN_REGISTER, 5'd4, 32'd0, sw_now);

    // Long receiver hold-off while the sender keeps offering.
    @(negedge clk);
    hold_off = 1;
    for (int i = 0; i < 32; i++)
      send_cmd(FN_SCHEDULE, 5'(31 - i), sw_now + $urandom_range(0, 60), sw_now);
    drain_all();
    sw_now = sw_now + 80;
    send_cmd(FN_TICK, 5'd0, 32'd0, sw_now);
    drain_all();

    // Random part with receiver stalls.
    stall_on = 1;
    for (int n = 0; n < 85; n++) begin
      random_cmd();
      if (n == 42) drain_all();
    end
    drain_all();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
